@@ sv/fbl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbl_pkg
// Shared types, constants and the CORDIC arctangent table for the five-bar
// leg inverse kinematics block.
// ----------------------------------------------------------------------------
package fbl_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int WINDING_BITS_DEF = 11;

  localparam int AW = 36;

  localparam logic signed [AW-1:0] PI_Q30       = 36'sd3373259426;
  localparam logic signed [AW-1:0] TWO_PI_Q30   = 36'sd6746518852;
  localparam logic signed [AW-1:0] ONE_Q30      = 36'sd1073741824;
  localparam logic        [31:0]   INV_GAIN_Q30 = 32'd652032874;

  localparam logic [1:0] CFG_SHORT_LINK = 2'd0;
  localparam logic [1:0] CFG_LONG_LINK  = 2'd1;
  localparam logic [1:0] CFG_FLIP_AXIS  = 2'd2;

  typedef struct packed {
    logic signed [15:0] foot_x;
    logic signed [15:0] foot_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] motor_a_angle;
    logic signed [31:0] motor_b_angle;
    logic               reachable;
  } out_req_t;

  function automatic logic signed [AW-1:0] atan_step(input logic [5:0] i);
    logic signed [AW-1:0] v;
    case (i)
      6'd0: v = 36'sd843314857;
      6'd1: v = 36'sd497837829;
      6'd2: v = 36'sd263043837;
      6'd3: v = 36'sd133525159;
      6'd4: v = 36'sd67021687;
      6'd5: v = 36'sd33543516;
      6'd6: v = 36'sd16775851;
      6'd7: v = 36'sd8388437;
      6'd8: v = 36'sd4194283;
      6'd9: v = 36'sd2097149;
      default: begin
        if (i <= 6'd30) v = AW'(1) << (6'd30 - i);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

@@ sv/fbl_cordic.sv @@
// ----------------------------------------------------------------------------
// fbl_cordic
// Vectoring CORDIC, one micro-rotation per cycle: atan2(y, x) in Q30 and the
// gain-scaled magnitude.
// ----------------------------------------------------------------------------
module fbl_cordic #(
  parameter int STEPS = fbl_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [fbl_pkg::AW-1:0]   x_in,
  input  logic signed [fbl_pkg::AW-1:0]   y_in,
  output logic                            done,
  output logic signed [fbl_pkg::AW-1:0]   ang,
  output logic signed [fbl_pkg::AW-1:0]   mag
);

  localparam int CW = $clog2(STEPS);

  logic                          busy_r, done_r;
  logic [CW-1:0]                 cnt_r;
  logic signed [fbl_pkg::AW-1:0] x_r, y_r, ang_r;
  logic signed [fbl_pkg::AW-1:0] dx, dy, da;

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign da = fbl_pkg::atan_step(6'(cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (x_in == '0 && y_in == '0) begin
          x_r    <= '0;
          y_r    <= '0;
          ang_r  <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          if (x_in < 0) begin
            ang_r <= (y_in >= 0) ? fbl_pkg::PI_Q30 : -fbl_pkg::PI_Q30;
            x_r   <= -x_in;
            y_r   <= -y_in;
          end else begin
            ang_r <= '0;
            x_r   <= x_in;
            y_r   <= y_in;
          end
        end
      end else if (busy_r) begin
        if (y_r >= 0) begin
          x_r   <= x_r + dx;
          y_r   <= y_r - dy;
          ang_r <= ang_r + da;
        end else begin
          x_r   <= x_r - dx;
          y_r   <= y_r + dy;
          ang_r <= ang_r - da;
        end
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign ang  = ang_r;
  assign mag  = x_r;

endmodule

@@ sv/fbl_div.sv @@
// ----------------------------------------------------------------------------
// fbl_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^30 / den) for
// num <= den.
// ----------------------------------------------------------------------------
module fbl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [30:0] quo
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [34:0] rem_r, trial;
  logic [32:0] den_r;
  logic [30:0] quo_r;

  assign trial = (cnt_r == 5'd0) ? rem_r : (rem_r << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= {2'b00, num};
        den_r  <= den;
        quo_r  <= '0;
      end else if (busy_r) begin
        if (trial >= {2'b00, den_r}) begin
          rem_r <= trial - {2'b00, den_r};
          quo_r <= {quo_r[29:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[29:0], 1'b0};
        end
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ sv/fbl_sqrt.sv @@
// ----------------------------------------------------------------------------
// fbl_sqrt
// Digit-by-digit floor square root of a Q60 value, one result bit per cycle.
// ----------------------------------------------------------------------------
module fbl_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [60:0] v_in,
  output logic        done,
  output logic [30:0] root
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [61:0] v_r, res_r, bit_r, sum;

  assign sum = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        v_r    <= {1'b0, v_in};
        res_r  <= '0;
        bit_r  <= 62'd1 << 60;
      end else if (busy_r) begin
        if (v_r >= sum) begin
          v_r   <= v_r - sum;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[30:0];

endmodule

@@ sv/five_bar_leg_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// five_bar_leg_inverse_kinematics
// Foot position to motor angles of a symmetric five-bar leg, sequenced over a
// shared CORDIC, a shared multiplier, a divider and a square-root unit.
//
//   channel | direction | ports                          | payload
//   in      | input     | in_valid, in_stall, in_data    | foot_x, foot_z
//   out     | output    | out_valid, out_stall, out_data | angles, reachable
//   cfg     | input     | cfg_wr_en, cfg_index, cfg_data | link lengths, flip
//
// A request runs from acceptance to the output register through two CORDIC
// passes, 31 divider steps and 31 square-root steps, run back to back.
// Unreachable targets skip the divider.
// in_stall is high from acceptance until the result is written to the output
// register; a result waiting on out_stall holds the block in its last step.
// Synchronous active-low reset clears control and winding state and restores the default configuration.
// ----------------------------------------------------------------------------
module five_bar_leg_inverse_kinematics #(
  parameter int CORDIC_STEPS = fbl_pkg::CORDIC_STEPS_DEF,
  parameter int WINDING_BITS = fbl_pkg::WINDING_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fbl_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fbl_pkg::out_req_t out_data,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int AW  = fbl_pkg::AW;
  localparam int WB  = WINDING_BITS;
  localparam int TW  = WB + 48;
  localparam int TSW = TW - 14;

  typedef enum logic [4:0] {
    S_IDLE, S_COR1, S_W1, S_RAD, S_W2, S_RSQ, S_W3, S_L1SQ, S_W4, S_L2SQ,
    S_W5, S_DEN, S_CHK, S_DIV, S_W6, S_SQ, S_SQW, S_COR2, S_TH, S_ANG, S_OUT
  } state_t;

  state_t state_r;

  logic [15:0] l1_r, l2_r;
  logic        flip_r;

  logic signed [WB-1:0] wind_r;
  logic                 last_zpos_r, seen_r;

  logic [31:0] mul_a_r, mul_b_r;
  logic [63:0] prod_r;

  logic signed [AW-1:0] bearing_r, alpha_r, c_r;
  logic [16:0]          r_r;
  logic signed [34:0]   acc_r;
  logic [32:0]          den_r;
  logic                 neg_r, reach_r;
  logic signed [TW-1:0] wpi_r;
  logic signed [TSW-1:0] ta_r, tb_r;

  logic                 out_valid_r;
  fbl_pkg::out_req_t    out_data_r;

  logic                 accept, zpos;
  logic signed [WB-1:0] wmax, wmin;

  logic                 cor_start, cor_done;
  logic signed [AW-1:0] cor_x, cor_y, cor_ang, cor_mag;
  logic                 div_start, div_done;
  logic [30:0]          div_quo;
  logic                 sq_start, sq_done;
  logic [30:0]          sq_root;

  logic [63:0]          rnd;
  logic [16:0]          r_nxt;
  logic                 acc_neg;
  logic [32:0]          unum;
  logic signed [TW-1:0] ta_full, tb_full;
  logic signed [TSW-1:0] ta_fin, tb_fin;

  function automatic logic signed [31:0] sat32(input logic signed [TSW-1:0] v);
    logic signed [31:0] o;
    if (v[TSW-1:31] == '0 || v[TSW-1:31] == '1) o = v[31:0];
    else if (v[TSW-1]) o = 32'sh8000_0000;
    else o = 32'sh7fff_ffff;
    return o;
  endfunction

  assign accept = in_valid && !in_stall;
  assign zpos   = in_data.foot_z > 16'sd0;
  assign wmax   = {1'b0, {(WB-1){1'b1}}};
  assign wmin   = {1'b1, {(WB-1){1'b0}}};

  assign rnd     = prod_r + (64'd1 << 43);
  assign r_nxt   = rnd[60:44];
  assign acc_neg = acc_r < 0;
  assign unum    = acc_neg ? 33'(-acc_r) : 33'(acc_r);

  assign ta_full = wpi_r - TW'(bearing_r) - TW'(alpha_r) + TW'(8192);
  assign tb_full = TW'(fbl_pkg::PI_Q30) - wpi_r + TW'(bearing_r) - TW'(alpha_r)
                 + TW'(8192);
  assign ta_fin  = flip_r ? -ta_r : ta_r;
  assign tb_fin  = flip_r ? -tb_r : tb_r;

  always_comb begin
    cor_start = 1'b0;
    cor_x     = '0;
    cor_y     = '0;
    if (accept) begin
      cor_start = 1'b1;
      cor_x     = AW'(in_data.foot_x) <<< 14;
      cor_y     = AW'(in_data.foot_z) <<< 14;
    end else if (state_r == S_SQW && sq_done) begin
      cor_start = 1'b1;
      cor_x     = c_r;
      cor_y     = AW'({1'b0, sq_root});
    end
  end

  assign div_start = (state_r == S_CHK) && den_r != '0 && unum <= den_r;
  assign sq_start  = (state_r == S_SQ);

  fbl_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x_in  (cor_x),
    .y_in  (cor_y),
    .done  (cor_done),
    .ang   (cor_ang),
    .mag   (cor_mag)
  );

  fbl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (unum),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  fbl_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .v_in  (61'((64'd1 << 60) - prod_r)),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      l1_r        <= 16'd4325;
      l2_r        <= 16'd9830;
      flip_r      <= 1'b0;
      wind_r      <= '0;
      last_zpos_r <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          fbl_pkg::CFG_SHORT_LINK: l1_r   <= cfg_data;
          fbl_pkg::CFG_LONG_LINK:  l2_r   <= cfg_data;
          fbl_pkg::CFG_FLIP_AXIS:  flip_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            seen_r      <= 1'b1;
            last_zpos_r <= zpos;
            if (seen_r && in_data.foot_x < 0 && zpos != last_zpos_r) begin
              if (zpos) begin
                if (wind_r < wmax) wind_r <= wind_r + 1'b1;
              end else begin
                if (wind_r > wmin) wind_r <= wind_r - 1'b1;
              end
            end
            state_r <= S_COR1;
          end
        end
        S_COR1: begin
          if (cor_done) begin
            bearing_r <= cor_ang;
            mul_a_r   <= cor_mag[31:0];
            mul_b_r   <= fbl_pkg::INV_GAIN_Q30;
            state_r   <= S_W1;
          end
        end
        S_W1: state_r <= S_RAD;
        S_RAD: begin
          r_r     <= r_nxt;
          mul_a_r <= 32'(r_nxt);
          mul_b_r <= 32'(r_nxt);
          state_r <= S_W2;
        end
        S_W2: state_r <= S_RSQ;
        S_RSQ: begin
          acc_r   <= 35'(prod_r);
          mul_a_r <= 32'(l1_r);
          mul_b_r <= 32'(l1_r);
          state_r <= S_W3;
        end
        S_W3: state_r <= S_L1SQ;
        S_L1SQ: begin
          acc_r   <= acc_r + 35'(prod_r);
          mul_a_r <= 32'(l2_r);
          mul_b_r <= 32'(l2_r);
          state_r <= S_W4;
        end
        S_W4: state_r <= S_L2SQ;
        S_L2SQ: begin
          acc_r   <= acc_r - 35'(prod_r);
          mul_a_r <= 32'(r_r);
          mul_b_r <= 32'(l1_r);
          state_r <= S_W5;
        end
        S_W5: state_r <= S_DEN;
        S_DEN: begin
          den_r   <= {prod_r[31:0], 1'b0};
          state_r <= S_CHK;
        end
        S_CHK: begin
          neg_r <= acc_neg;
          if (div_start) begin
            reach_r <= 1'b1;
            state_r <= S_DIV;
          end else begin
            reach_r <= 1'b0;
            c_r     <= acc_neg ? -fbl_pkg::ONE_Q30 : fbl_pkg::ONE_Q30;
            mul_a_r <= 32'(fbl_pkg::ONE_Q30);
            mul_b_r <= 32'(fbl_pkg::ONE_Q30);
            state_r <= S_W6;
          end
        end
        S_DIV: begin
          if (div_done) begin
            c_r     <= neg_r ? -AW'({1'b0, div_quo}) : AW'({1'b0, div_quo});
            mul_a_r <= 32'(div_quo);
            mul_b_r <= 32'(div_quo);
            state_r <= S_W6;
          end
        end
        S_W6: state_r <= S_SQ;
        S_SQ: state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) state_r <= S_COR2;
        end
        S_COR2: begin
          if (cor_done) begin
            alpha_r <= cor_ang;
            state_r <= S_TH;
          end
        end
        S_TH: begin
          wpi_r   <= TW'(wind_r) * TW'(fbl_pkg::TWO_PI_Q30);
          state_r <= S_ANG;
        end
        S_ANG: begin
          ta_r    <= TSW'(ta_full >>> 14);
          tb_r    <= TSW'(tb_full >>> 14);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.motor_a_angle <= sat32(ta_fin);
            out_data_r.motor_b_angle <= sat32(tb_fin);
            out_data_r.reachable     <= reach_r;
            out_valid_r              <= 1'b1;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_clamp_c: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W6 && !reach_r) |->
      (c_r == fbl_pkg::ONE_Q30 || c_r == -fbl_pkg::ONE_Q30))
    else $error("unreachable target without clamped cosine");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside final step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r == S_OUT) |=> state_r == S_OUT)
    else $error("pending result overwritten");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for five_bar_leg_inverse_kinematics. Foot positions are sent over
// the valid/stall request channel with random gaps and output stalls. A local
// model computes the expected motor angles, reachable flag and winding
// continuity for each request, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  fbl_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_stall;
  fbl_pkg::out_req_t out_data;
  logic              cfg_wr_en;
  logic [1:0]        cfg_index;
  logic [15:0]       cfg_data;

  five_bar_leg_inverse_kinematics u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int WBITS = fbl_pkg::WINDING_BITS_DEF;
  localparam int NSTEPS = fbl_pkg::CORDIC_STEPS_DEF;

  logic [15:0]       link_short;
  logic [15:0]       link_long;
  logic              mirror;
  int                wind;
  bit                prev_zpos;
  bit                primed;
  fbl_pkg::out_req_t angle_q[$];
  int                mismatches;
  int                out_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic longint shr_s(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  function automatic longint vector_angle(longint xi, longint yi, output longint mag);
    longint x, y, ang, dx, dy;
    x = xi;
    y = yi;
    ang = 0;
    mag = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSTEPS; i++) begin
      dx = shr_s(y, i);
      dy = shr_s(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; ang += arctan_step(i);
      end else begin
        x -= dx; y += dy; ang -= arctan_step(i);
      end
    end
    mag = x;
    return ang;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic fbl_pkg::out_req_t leg_angles(fbl_pkg::in_req_t req);
    fbl_pkg::out_req_t r;
    longint x, z, mag, bearing, rad, l1, l2, num, den, c, s, alpha, th0, ta, tb, q;
    longint unsigned unum;
    bit zpos, ok;
    int wmax, wmin;
    x = req.foot_x;
    z = req.foot_z;
    zpos = z > 0;
    wmax = (1 << (WBITS - 1)) - 1;
    wmin = -wmax - 1;
    ok = 1;
    if (!primed) primed = 1;
    else if (x < 0 && zpos != prev_zpos) begin
      if (zpos) begin
        if (wind < wmax) wind++;
      end else if (wind > wmin) wind--;
    end
    prev_zpos = zpos;
    bearing = vector_angle(x * 16384, z * 16384, mag);
    rad = (mag * 652032874 + (longint'(1) << 43)) >>> 44;
    l1 = link_short;
    l2 = link_long;
    num = rad * rad + l1 * l1 - l2 * l2;
    den = 2 * rad * l1;
    unum = (num < 0) ? -num : num;
    if (den == 0 || unum > longint'(den)) begin
      ok = 0;
      c = (num < 0) ? -64'sd1073741824 : 64'sd1073741824;
    end else begin
      q = (unum << 30) / den;
      c = (num < 0) ? -q : q;
    end
    s = floor_sqrt((64'd1 << 60) - c * c);
    alpha = vector_angle(c, s, mag);
    th0 = 2 * 64'sd3373259426 * longint'(wind) - bearing;
    ta = shr_s(th0 - alpha + 8192, 14);
    tb = shr_s(64'sd3373259426 - th0 - alpha + 8192, 14);
    if (mirror) begin
      ta = -ta; tb = -tb;
    end
    r.motor_a_angle = clip32(ta);
    r.motor_b_angle = clip32(tb);
    r.reachable = ok;
    return r;
  endfunction

  always @(posedge clk) begin
    fbl_pkg::out_req_t e;
    if (rst_n && out_valid && !out_stall) begin
      out_count++;
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = angle_q.pop_front();
        if (out_data.motor_a_angle !== e.motor_a_angle ||
            out_data.motor_b_angle !== e.motor_b_angle ||
            out_data.reachable !== e.reachable) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp a=%0d b=%0d r=%0b got a=%0d b=%0d r=%0b",
                     e.motor_a_angle, e.motor_b_angle, e.reachable,
                     out_data.motor_a_angle, out_data.motor_b_angle,
                     out_data.reachable);
        end
      end
    end
  end

  initial begin
    int g;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        g = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  task automatic send_pos(logic [15:0] x, logic [15:0] z, bit calm = 0);
    fbl_pkg::in_req_t req;
    int g;
    g = calm ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 2) == 0) g = 0;
    repeat (g + 1) @(posedge clk);
    req.foot_x = x;
    req.foot_z = z;
    angle_q.push_back(leg_angles(req));
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (angle_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      fbl_pkg::CFG_SHORT_LINK: link_short = v;
      fbl_pkg::CFG_LONG_LINK:  link_long = v;
      default:                 mirror = v[0];
    endcase
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_pos(16'h0000, 16'h0000);
    send_pos(16'h7FFF, 16'h7FFF);
    send_pos(16'h8000, 16'h8000);
    send_pos(16'h8000, 16'h7FFF);
    send_pos(16'h7FFF, 16'h8000);
    send_pos(16'h0000, 16'h1000);
    send_pos(16'd10000, 16'd0);
    send_pos(-16'sd3000, -16'sd8000);
    send_pos(-16'sd3000, 16'sd8000);
    send_pos(-16'sd3000, 16'sd0);
    send_pos(16'sd0, -16'sd12000);
    send_pos(16'sd20, 16'sd10);
    send_pos(16'sd1, 16'sd0);
    drain();
  endtask

  task automatic test_winding();
    for (int i = 0; i < 300; i++)
      send_pos(-16'($urandom_range(1, 20000)),
               (i % 2) ? 16'($urandom_range(1, 20000)) : -16'($urandom_range(0, 20000)),
               1);
    drain();
    for (int i = 0; i < 400; i++)
      send_pos((i % 2) ? 16'sd5000 : -16'sd5000, (i % 2) ? -16'sd5000 : 16'sd5000, 1);
    drain();
    for (int i = 0; i < 400; i++)
      send_pos((i % 2) ? 16'sd5000 : -16'sd5000, (i % 2) ? 16'sd5000 : -16'sd5000, 1);
    drain();
  endtask

  task automatic test_config_sweep();
    logic [15:0] s_len[4] = '{16'd0, 16'hFFFF, 16'd4325, 16'd12000};
    logic [15:0] l_len[4] = '{16'hFFFF, 16'd0, 16'd9830, 16'd100};
    for (int k = 0; k < 4; k++) begin
      write_reg(fbl_pkg::CFG_SHORT_LINK, s_len[k]);
      write_reg(fbl_pkg::CFG_LONG_LINK, l_len[k]);
      write_reg(fbl_pkg::CFG_FLIP_AXIS, 16'(k % 2));
      for (int i = 0; i < 20; i++) send_pos(16'($urandom), 16'($urandom));
      drain();
    end
    write_reg(fbl_pkg::CFG_SHORT_LINK, 16'd4325);
    write_reg(fbl_pkg::CFG_LONG_LINK, 16'd9830);
    write_reg(fbl_pkg::CFG_FLIP_AXIS, 16'd0);
  endtask

  task automatic test_random();
    logic [15:0] x, z;
    int m;
    for (int i = 0; i < 360; i++) begin
      if (i % 120 == 119) begin
        drain();
        write_reg(fbl_pkg::CFG_SHORT_LINK, 16'($urandom_range(1000, 20000)));
        write_reg(fbl_pkg::CFG_LONG_LINK, 16'($urandom_range(1000, 30000)));
        write_reg(fbl_pkg::CFG_FLIP_AXIS, 16'($urandom_range(0, 1)));
      end
      m = $urandom_range(0, 3);
      if (m == 0) begin
        x = 16'($urandom);
        z = 16'($urandom);
      end else begin
        x = 16'($signed(16'($urandom_range(0, 30000))) - 16'sd15000);
        z = 16'($signed(16'($urandom_range(0, 30000))) - 16'sd15000);
      end
      send_pos(x, z);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = fbl_pkg::CFG_SHORT_LINK;
    cfg_data = '0;
    link_short = 16'd4325;
    link_long = 16'd9830;
    mirror = 1'b0;
    wind = 0;
    prev_zpos = 0;
    primed = 0;
    mismatches = 0;
    out_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_winding();
    test_config_sweep();
    test_random();
    if (mismatches == 0 && angle_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/fbl_pkg.sv
sv/fbl_cordic.sv
sv/fbl_div.sv
sv/fbl_sqrt.sv
sv/five_bar_leg_inverse_kinematics.sv
sim/tb_top.sv
